// ===== hdl/hvt_pkg.sv =====
// Shared constants, types and helpers of the homogeneous vector transform.
`default_nettype none

package hvt_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int DATA_W     = 32;
   localparam int VEC_N      = 4;
   localparam int PROD_W     = 2 * DATA_W;
   localparam int PAIR_W     = PROD_W + 1;
   localparam int SUM_W      = PROD_W + 2;
   localparam int MAC_STAGES = 4;

   localparam int NUM_REGS   = 8;
   localparam int REG_W      = 2 * DATA_W;
   localparam int REG_IDX_W  = $clog2(NUM_REGS);
   localparam int ADDR_LSB   = $clog2(REG_W / 8);
   localparam int CSR_ADDR_W = REG_IDX_W + ADDR_LSB;

   localparam int DEN_W      = DATA_W;
   localparam int NUM_W      = DATA_W + FRAC_BITS;
   localparam int DIV_BPS    = 2;
   localparam int DIV_STAGES = (NUM_W + DIV_BPS - 1) / DIV_BPS;
   localparam int QPAD_W     = DIV_STAGES * DIV_BPS;

   localparam logic CMD_VECTOR = 1'b0;
   localparam logic CMD_POINT  = 1'b1;

   localparam logic [DATA_W-1:0] ONE_FIX = DATA_W'(1) << FRAC_BITS;
   localparam logic [DATA_W-1:0] WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_SAT  = 2'd1,
      STATUS_DIV0 = 2'd2
   } status_type;

   // Element [k][j] multiplies input component k into output column j.
   typedef logic [VEC_N-1:0][VEC_N-1:0][DATA_W-1:0] matrix_type;

   typedef struct packed {
      logic                          cmd;
      logic [VEC_N-1:0][DATA_W-1:0]  vec;
   } req_type;

   typedef struct packed {
      logic [DEN_W-1:0]  rem;
      logic [QPAD_W-1:0] nq;
      logic              neg;
   } lane_type;

   typedef struct packed {
      lane_type [VEC_N-1:0] lane;
      logic [DEN_W-1:0]     den;
      logic                 sat;
      logic                 zero;
   } div_type;

   typedef struct packed {
      logic [VEC_N-1:0][DATA_W-1:0] vec;
      status_type                   status;
   } rsp_type;

   // Reset value of a matrix register: the identity matrix.
   function automatic logic [REG_W-1:0] reg_reset(input int idx);
      logic [REG_W-1:0] v;
      int               row;
      int               col;
      v   = '0;
      row = idx >> 1;
      for (int h = 0; h < 2; h++) begin
         col = ((idx & 1) << 1) + h;
         if (col == row) begin
            v[h*DATA_W +: DATA_W] = ONE_FIX;
         end
      end
      return v;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/hvt_req_if.sv =====
// Input channel of the homogeneous vector transform: command and vector.
`default_nettype none

interface hvt_req_if;
   logic                                valid;
   logic                                ready;
   logic                                cmd;
   logic signed [hvt_pkg::DATA_W-1:0]   in_x;
   logic signed [hvt_pkg::DATA_W-1:0]   in_y;
   logic signed [hvt_pkg::DATA_W-1:0]   in_z;
   logic signed [hvt_pkg::DATA_W-1:0]   in_w;

   modport source (output valid, cmd, in_x, in_y, in_z, in_w, input ready);
   modport sink   (input valid, cmd, in_x, in_y, in_z, in_w, output ready);
endinterface

`default_nettype wire

// ===== hdl/hvt_rsp_if.sv =====
// Result channel of the homogeneous vector transform: vector and status.
`default_nettype none

interface hvt_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [hvt_pkg::DATA_W-1:0]   out_x;
   logic signed [hvt_pkg::DATA_W-1:0]   out_y;
   logic signed [hvt_pkg::DATA_W-1:0]   out_z;
   logic signed [hvt_pkg::DATA_W-1:0]   out_w;
   logic [1:0]                          status;

   modport source (output valid, out_x, out_y, out_z, out_w, status, input ready);
   modport sink   (input valid, out_x, out_y, out_z, out_w, status, output ready);
endinterface

`default_nettype wire

// ===== hdl/hvt_csr.sv =====
// APB register file holding the 4x4 transform matrix.
`default_nettype none

module hvt_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [hvt_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [hvt_pkg::REG_W-1:0]         pwdata,
   output logic [hvt_pkg::REG_W-1:0]         prdata,
   output logic                              pready,
   output hvt_pkg::matrix_type               matrix
);

   logic [hvt_pkg::REG_W-1:0]     regs_ff [hvt_pkg::NUM_REGS];
   logic [hvt_pkg::REG_IDX_W-1:0] idx;

   assign idx    = paddr[hvt_pkg::CSR_ADDR_W-1:hvt_pkg::ADDR_LSB];
   assign pready = 1'b1;
   assign prdata = regs_ff[idx];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < hvt_pkg::NUM_REGS; i++) begin
            regs_ff[i] <= hvt_pkg::reg_reset(i);
         end
      end else if (psel && penable && pwrite) begin
         regs_ff[idx] <= pwdata;
      end
   end

   // Each register carries two columns of one row: even column low, odd column high.
   always_comb begin
      for (int k = 0; k < hvt_pkg::VEC_N; k++) begin
         for (int j = 0; j < hvt_pkg::VEC_N; j++) begin
            matrix[k][j] = regs_ff[hvt_pkg::REG_IDX_W'((k << 1) + (j >> 1))]
                                  [(j & 1) * hvt_pkg::DATA_W +: hvt_pkg::DATA_W];
         end
      end
   end

endmodule

`default_nettype wire

// ===== hdl/hvt_mac.sv =====
// Matrix multiply pipeline: products, pair sums, column sums with saturation, divide setup.
`default_nettype none

module hvt_mac (
   input  logic                 clock,
   input  logic                 reset,
   input  hvt_pkg::matrix_type  matrix,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  hvt_pkg::req_type     in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output hvt_pkg::div_type     out_data
);

   localparam int MAC_STAGES = hvt_pkg::MAC_STAGES;

   logic [MAC_STAGES-1:0] vld_ff;
   logic [MAC_STAGES-1:0] vld_src;
   logic [MAC_STAGES:0]   rdy;

   assign rdy[MAC_STAGES] = out_ready;
   assign vld_src         = {vld_ff[MAC_STAGES-2:0], in_valid};
   assign in_ready        = rdy[0];

   // A stage takes new data when it is empty or its successor moves on.
   for (genvar i = 0; i < MAC_STAGES; i++) begin : g_rdy
      assign rdy[i] = !vld_ff[i] || rdy[i+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int i = 0; i < MAC_STAGES; i++) begin
            if (rdy[i]) begin
               vld_ff[i] <= vld_src[i];
            end
         end
      end
   end

   // Stage A: sixteen 32x32 products.
   logic signed [hvt_pkg::DATA_W-1:0] vin [hvt_pkg::VEC_N];
   logic signed [hvt_pkg::PROD_W-1:0] prod_in [hvt_pkg::VEC_N][hvt_pkg::VEC_N];
   logic signed [hvt_pkg::PROD_W-1:0] prod_ff [hvt_pkg::VEC_N][hvt_pkg::VEC_N];
   logic                              a_cmd_ff;

   always_comb begin
      for (int k = 0; k < hvt_pkg::VEC_N; k++) begin
         vin[k] = in_data.vec[k];
      end
      if (in_data.cmd == hvt_pkg::CMD_POINT) begin
         vin[hvt_pkg::VEC_N-1] = hvt_pkg::ONE_FIX;
      end
      for (int k = 0; k < hvt_pkg::VEC_N; k++) begin
         for (int j = 0; j < hvt_pkg::VEC_N; j++) begin
            prod_in[k][j] = hvt_pkg::PROD_W'(vin[k])
                          * hvt_pkg::PROD_W'($signed(matrix[k][j]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0] && vld_src[0]) begin
         a_cmd_ff <= in_data.cmd;
         prod_ff  <= prod_in;
      end
   end

   // Stage B: rows 0+1 and rows 2+3 per column.
   logic signed [hvt_pkg::PAIR_W-1:0] pair_in [2][hvt_pkg::VEC_N];
   logic signed [hvt_pkg::PAIR_W-1:0] pair_ff [2][hvt_pkg::VEC_N];
   logic                              b_cmd_ff;

   always_comb begin
      for (int h = 0; h < 2; h++) begin
         for (int j = 0; j < hvt_pkg::VEC_N; j++) begin
            pair_in[h][j] = hvt_pkg::PAIR_W'(prod_ff[2*h][j])
                          + hvt_pkg::PAIR_W'(prod_ff[2*h+1][j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[1] && vld_src[1]) begin
         b_cmd_ff <= a_cmd_ff;
         pair_ff  <= pair_in;
      end
   end

   // Stage C: full sum, floor shift and clamp to the word range.
   logic signed [hvt_pkg::SUM_W-1:0]  sum_c [hvt_pkg::VEC_N];
   logic signed [hvt_pkg::SUM_W-1:0]  shr_c [hvt_pkg::VEC_N];
   logic [hvt_pkg::SUM_W-hvt_pkg::DATA_W:0] hi_c [hvt_pkg::VEC_N];
   logic [hvt_pkg::VEC_N-1:0]         fits_c;
   logic [hvt_pkg::DATA_W-1:0]        r_in [hvt_pkg::VEC_N];
   logic [hvt_pkg::DATA_W-1:0]        r_ff [hvt_pkg::VEC_N];
   logic                              c_cmd_ff;
   logic                              c_sat_ff;

   always_comb begin
      for (int j = 0; j < hvt_pkg::VEC_N; j++) begin
         sum_c[j]  = hvt_pkg::SUM_W'(pair_ff[0][j]) + hvt_pkg::SUM_W'(pair_ff[1][j]);
         shr_c[j]  = sum_c[j] >>> hvt_pkg::FRAC_BITS;
         hi_c[j]   = shr_c[j][hvt_pkg::SUM_W-1:hvt_pkg::DATA_W-1];
         fits_c[j] = (&hi_c[j]) || !(|hi_c[j]);
         if (fits_c[j]) begin
            r_in[j] = shr_c[j][hvt_pkg::DATA_W-1:0];
         end else if (shr_c[j][hvt_pkg::SUM_W-1]) begin
            r_in[j] = hvt_pkg::WORD_MIN;
         end else begin
            r_in[j] = hvt_pkg::WORD_MAX;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[2] && vld_src[2]) begin
         c_cmd_ff <= b_cmd_ff;
         c_sat_ff <= !(&fits_c);
         r_ff     <= r_in;
      end
   end

   // Stage D: magnitudes and signs for the divider. A plain transform divides
   // the unscaled magnitude by one, so the magnitude passes through the divider unchanged.
   logic [hvt_pkg::DATA_W-1:0] d_word;
   logic [hvt_pkg::DATA_W-1:0] d_mag;
   logic [hvt_pkg::DATA_W-1:0] mag [hvt_pkg::VEC_N];
   logic                       point;
   logic                       d_zero;
   hvt_pkg::div_type           prep_in;
   hvt_pkg::div_type           prep_ff;

   always_comb begin
      point   = (c_cmd_ff == hvt_pkg::CMD_POINT);
      d_word  = r_ff[hvt_pkg::VEC_N-1];
      d_mag   = d_word[hvt_pkg::DATA_W-1] ? (~d_word + 1'b1) : d_word;
      d_zero  = (d_word == '0);
      prep_in.sat  = c_sat_ff;
      prep_in.zero = point && d_zero;
      prep_in.den  = (point && !d_zero) ? d_mag : hvt_pkg::DEN_W'(1);
      for (int j = 0; j < hvt_pkg::VEC_N; j++) begin
         mag[j] = r_ff[j][hvt_pkg::DATA_W-1] ? (~r_ff[j] + 1'b1) : r_ff[j];
         prep_in.lane[j].rem = '0;
         if (point) begin
            prep_in.lane[j].nq  = hvt_pkg::QPAD_W'(mag[j]) << hvt_pkg::FRAC_BITS;
            prep_in.lane[j].neg = r_ff[j][hvt_pkg::DATA_W-1] ^ d_word[hvt_pkg::DATA_W-1];
         end else begin
            prep_in.lane[j].nq  = hvt_pkg::QPAD_W'(mag[j]);
            prep_in.lane[j].neg = r_ff[j][hvt_pkg::DATA_W-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[3] && vld_src[3]) begin
         prep_ff <= prep_in;
      end
   end

   assign out_valid = vld_ff[MAC_STAGES-1];
   assign out_data  = prep_ff;

   a_zero_den_one: assert property (@(posedge clock) disable iff (reset)
      out_valid && out_data.zero |-> out_data.den == hvt_pkg::DEN_W'(1))
      else $error("zero divisor item does not divide by one");

   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> out_data.den != '0)
      else $error("divider receives a zero divisor");

endmodule

`default_nettype wire

// ===== hdl/hvt_div.sv =====
// Pipelined restoring divider for four lanes, with sign fix, clamp and status output register.
`default_nettype none

module hvt_div (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  hvt_pkg::div_type  in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output hvt_pkg::rsp_type  out_data
);

   localparam int LAST = hvt_pkg::DIV_STAGES - 1;
   localparam logic [hvt_pkg::QPAD_W-1:0] NEG_LIM = hvt_pkg::QPAD_W'(1) << (hvt_pkg::DATA_W - 1);
   localparam logic [hvt_pkg::QPAD_W-1:0] POS_LIM = NEG_LIM - 1'b1;

   // DIV_BPS quotient bits per lane; the dividend shifts out at the top of nq
   // while quotient bits shift in at the bottom.
   function automatic hvt_pkg::div_type div_step(input hvt_pkg::div_type d);
      hvt_pkg::div_type        r;
      logic [hvt_pkg::DEN_W:0] sh;
      r = d;
      for (int l = 0; l < hvt_pkg::VEC_N; l++) begin
         for (int b = 0; b < hvt_pkg::DIV_BPS; b++) begin
            sh = {r.lane[l].rem, r.lane[l].nq[hvt_pkg::QPAD_W-1]};
            r.lane[l].nq = {r.lane[l].nq[hvt_pkg::QPAD_W-2:0], 1'b0};
            if (sh >= {1'b0, r.den}) begin
               r.lane[l].rem   = hvt_pkg::DEN_W'(sh - {1'b0, r.den});
               r.lane[l].nq[0] = 1'b1;
            end else begin
               r.lane[l].rem = sh[hvt_pkg::DEN_W-1:0];
            end
         end
      end
      return r;
   endfunction

   hvt_pkg::div_type                stage_ff [hvt_pkg::DIV_STAGES];
   hvt_pkg::div_type                stage_in [hvt_pkg::DIV_STAGES];
   logic [hvt_pkg::DIV_STAGES-1:0]  vld_ff;
   logic [hvt_pkg::DIV_STAGES-1:0]  vld_src;
   logic [hvt_pkg::DIV_STAGES:0]    rdy;
   logic                            out_go;
   logic                            out_vld_ff;
   hvt_pkg::rsp_type                res_ff;
   hvt_pkg::rsp_type                res_in;

   assign out_go                   = !out_vld_ff || out_ready;
   assign rdy[hvt_pkg::DIV_STAGES] = out_go;
   assign vld_src                  = {vld_ff[hvt_pkg::DIV_STAGES-2:0], in_valid};
   assign in_ready                 = rdy[0];

   for (genvar i = 0; i < hvt_pkg::DIV_STAGES; i++) begin : g_rdy
      assign rdy[i] = !vld_ff[i] || rdy[i+1];
   end

   always_comb begin
      stage_in[0] = div_step(in_data);
      for (int i = 1; i < hvt_pkg::DIV_STAGES; i++) begin
         stage_in[i] = div_step(stage_ff[i-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int i = 0; i < hvt_pkg::DIV_STAGES; i++) begin
            if (rdy[i]) begin
               vld_ff[i] <= vld_src[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < hvt_pkg::DIV_STAGES; i++) begin
         if (rdy[i] && vld_src[i]) begin
            stage_ff[i] <= stage_in[i];
         end
      end
   end

   // Sign fix and clamp of the truncated quotients.
   logic [hvt_pkg::QPAD_W-1:0] q    [hvt_pkg::VEC_N];
   logic [hvt_pkg::QPAD_W-1:0] negq [hvt_pkg::VEC_N];
   logic [hvt_pkg::VEC_N-1:0]  qsat;

   always_comb begin
      for (int l = 0; l < hvt_pkg::VEC_N; l++) begin
         q[l]    = stage_ff[LAST].lane[l].nq;
         negq[l] = ~q[l] + 1'b1;
         if (stage_ff[LAST].lane[l].neg) begin
            qsat[l] = (q[l] > NEG_LIM);
            res_in.vec[l] = qsat[l] ? hvt_pkg::WORD_MIN : negq[l][hvt_pkg::DATA_W-1:0];
         end else begin
            qsat[l] = (q[l] > POS_LIM);
            res_in.vec[l] = qsat[l] ? hvt_pkg::WORD_MAX : q[l][hvt_pkg::DATA_W-1:0];
         end
      end
      if (stage_ff[LAST].zero) begin
         res_in.vec    = '0;
         res_in.status = hvt_pkg::STATUS_DIV0;
      end else if (stage_ff[LAST].sat || (|qsat)) begin
         res_in.status = hvt_pkg::STATUS_SAT;
      end else begin
         res_in.status = hvt_pkg::STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (out_go) begin
         out_vld_ff <= vld_ff[LAST];
      end
   end

   always_ff @(posedge clock) begin
      if (out_go && vld_ff[LAST]) begin
         res_ff <= res_in;
      end
   end

   assign out_valid = out_vld_ff;
   assign out_data  = res_ff;

   a_last_to_out: assert property (@(posedge clock) disable iff (reset)
      vld_ff[LAST] && out_go |=> out_vld_ff)
      else $error("finished quotient did not reach the output register");

   a_div0_zero: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && res_ff.status == hvt_pkg::STATUS_DIV0 |-> res_ff.vec == '0)
      else $error("divide by zero result is not all zero");

   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      vld_ff[LAST] |-> stage_ff[LAST].lane[0].rem < stage_ff[LAST].den
                    && stage_ff[LAST].lane[1].rem < stage_ff[LAST].den
                    && stage_ff[LAST].lane[2].rem < stage_ff[LAST].den
                    && stage_ff[LAST].lane[3].rem < stage_ff[LAST].den)
      else $error("divider remainder not below divisor");

endmodule

`default_nettype wire

// ===== hdl/homogeneous_vector_transform.sv =====
// Top level of the homogeneous vector transform: registers, multiply pipeline, divider.
//
// Multiplies the row vector (x, y, z, w) by the 4x4 Q16.16 matrix held in eight
// 64-bit APB registers (reset value: identity) and returns one result item per
// input item, in order. Command 0 gives the plain four-component product; command 1
// takes w as 1.0 and divides all four sums by the w sum, rounding toward zero
// (status 2 and all-zero outputs when that sum is zero). Sums and quotients that
// leave the Q16.16 range saturate and report status 1. The block accepts one item
// per clock cycle while the result side keeps up, and fills in any bubbles while
// the result side stalls. From input accept to result valid an item passes four
// multiply, sum and divide setup stages, then a restoring divider that retires
// two quotient bits per stage over the 48-bit scaled dividend, then the output
// register. No clearing pass follows reset.
`default_nettype none

module homogeneous_vector_transform (
   input  logic                              clock,
   input  logic                              reset,
   hvt_req_if.sink                           req_ch,
   hvt_rsp_if.source                         rsp_ch,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [hvt_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [hvt_pkg::REG_W-1:0]         csr_pwdata,
   output logic [hvt_pkg::REG_W-1:0]         csr_prdata,
   output logic                              csr_pready
);

   hvt_pkg::matrix_type matrix;
   hvt_pkg::req_type    req_data;
   hvt_pkg::div_type    mac_data;
   hvt_pkg::rsp_type    rsp_data;
   logic                mac_valid;
   logic                mac_ready;

   hvt_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .matrix  (matrix)
   );

   assign req_data.cmd    = req_ch.cmd;
   assign req_data.vec[0] = req_ch.in_x;
   assign req_data.vec[1] = req_ch.in_y;
   assign req_data.vec[2] = req_ch.in_z;
   assign req_data.vec[3] = req_ch.in_w;

   hvt_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .matrix    (matrix),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .in_data   (req_data),
      .out_valid (mac_valid),
      .out_ready (mac_ready),
      .out_data  (mac_data)
   );

   hvt_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mac_valid),
      .in_ready  (mac_ready),
      .in_data   (mac_data),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_data  (rsp_data)
   );

   assign rsp_ch.out_x  = rsp_data.vec[0];
   assign rsp_ch.out_y  = rsp_data.vec[1];
   assign rsp_ch.out_z  = rsp_data.vec[2];
   assign rsp_ch.out_w  = rsp_data.vec[3];
   assign rsp_ch.status = rsp_data.status;

endmodule

`default_nettype wire

// ===== tb/sv/homogeneous_vector_transform_tb.sv =====
// Self-checking testbench of the homogeneous vector transform with its own result predictor.
`default_nettype none

module homogeneous_vector_transform_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int PIPE_LATENCY = hvt_pkg::MAC_STAGES + hvt_pkg::DIV_STAGES + 1;
   localparam int SETTLE_CYCLES = PIPE_LATENCY + 8;
   localparam int RESET_CYCLES = 3;
   // The limit covers the worst case with both sides at their longest
   // bursts, plus the long receiver hold and the register writes.
   localparam int CYCLE_LIMIT = 400_000;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_ITEMS = 100;
   localparam int HOLD_ITEMS = 150;
   localparam int HOLD_CYCLES = 300;
   localparam int FULL_RATE_ITEMS = 150;

   localparam logic [hvt_pkg::DATA_W-1:0] ONE_HALF = 32'h0000_8000;
   localparam logic [hvt_pkg::DATA_W-1:0] NEG_HALF = 32'hFFFF_8000;
   localparam logic [hvt_pkg::DATA_W-1:0] NEG_ONE = 32'hFFFF_0000;
   localparam logic [hvt_pkg::DATA_W-1:0] NEG_THREE = 32'hFFFD_0000;
   localparam logic [hvt_pkg::DATA_W-1:0] NEG_2P5 = 32'hFFFD_8000;
   localparam logic [hvt_pkg::DATA_W-1:0] POS_3P25 = 32'h0003_4000;
   localparam logic [hvt_pkg::DATA_W-1:0] ALL_ONES = 32'hFFFF_FFFF;

   typedef enum int {
      ROW0_COLS01 = 0,
      ROW0_COLS23 = 1,
      ROW1_COLS01 = 2,
      ROW1_COLS23 = 3,
      ROW2_COLS01 = 4,
      ROW2_COLS23 = 5,
      ROW3_COLS01 = 6,
      ROW3_COLS23 = 7
   } matrix_reg_type;

   typedef logic [hvt_pkg::REG_W-1:0] matrix_regs_type [hvt_pkg::NUM_REGS];

   typedef struct packed {
      logic [hvt_pkg::VEC_N-1:0][hvt_pkg::DATA_W-1:0] comp;
      hvt_pkg::status_type                            status;
   } transform_result_type;

   logic clock = 1'b0;
   logic reset;

   hvt_req_if req ();
   hvt_rsp_if rsp ();

   logic                           csr_psel;
   logic                           csr_penable;
   logic                           csr_pwrite;
   logic [hvt_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [hvt_pkg::REG_W-1:0]      csr_pwdata;
   logic [hvt_pkg::REG_W-1:0]      csr_prdata;
   logic                           csr_pready;

   matrix_regs_type       matrix_shadow;
   transform_result_type  pending_results[$];
   string                 comp_name [hvt_pkg::VEC_N] = '{"out_x", "out_y", "out_z", "out_w"};

   int  error_count = 0;
   int  cycle_count = 0;
   int  point_items = 0;
   int  vector_items = 0;
   int  matrix_loads = 0;
   int  status_seen [3] = '{0, 0, 0};
   bit  sender_idle = 1'b1;
   bit  receiver_idle = 1'b1;
   int  hold_cycles = 0;

   homogeneous_vector_transform dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req),
      .rsp_ch      (rsp),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
         $display("tb: failure");
         $finish;
      end
   end

   function automatic matrix_regs_type identity_regs();
      matrix_regs_type r;
      for (int i = 0; i < hvt_pkg::NUM_REGS; i++) begin
         r[i] = '0;
      end
      r[ROW0_COLS01] = {32'h0, hvt_pkg::ONE_FIX};
      r[ROW1_COLS01] = {hvt_pkg::ONE_FIX, 32'h0};
      r[ROW2_COLS23] = {32'h0, hvt_pkg::ONE_FIX};
      r[ROW3_COLS23] = {hvt_pkg::ONE_FIX, 32'h0};
      return r;
   endfunction

   function automatic matrix_regs_type uniform_regs(logic [hvt_pkg::DATA_W-1:0] elem);
      matrix_regs_type r;
      for (int i = 0; i < hvt_pkg::NUM_REGS; i++) begin
         r[i] = {elem, elem};
      end
      return r;
   endfunction

   function automatic logic [hvt_pkg::DATA_W-1:0] matrix_elem(int row, int col);
      return matrix_shadow[row * 2 + col / 2][(col % 2) * hvt_pkg::DATA_W +: hvt_pkg::DATA_W];
   endfunction

   function automatic longint clamp_word(logic signed [127:0] v, inout logic saturated);
      if (v > 128'sh7FFF_FFFF) begin
         saturated = 1'b1;
         return 64'sh7FFF_FFFF;
      end
      if (v < -128'sh8000_0000) begin
         saturated = 1'b1;
         return -64'sh8000_0000;
      end
      return longint'(v);
   endfunction

   // Row vector times matrix with exact sums, then the optional divide by w.
   function automatic transform_result_type transform_vector(logic cmd,
                                                             logic [hvt_pkg::DATA_W-1:0] x,
                                                             logic [hvt_pkg::DATA_W-1:0] y,
                                                             logic [hvt_pkg::DATA_W-1:0] z,
                                                             logic [hvt_pkg::DATA_W-1:0] w);
      logic [hvt_pkg::VEC_N-1:0][hvt_pkg::DATA_W-1:0] comp_in;
      longint                       col_sum [hvt_pkg::VEC_N];
      logic signed [127:0]          acc;
      longint                       a;
      longint                       b;
      longint                       divisor;
      logic signed [127:0]          quot;
      logic                         saturated;
      transform_result_type         res;
      comp_in = {w, z, y, x};
      if (cmd == hvt_pkg::CMD_POINT) begin
         comp_in[3] = hvt_pkg::ONE_FIX;
      end
      saturated = 1'b0;
      for (int j = 0; j < hvt_pkg::VEC_N; j++) begin
         acc = '0;
         for (int k = 0; k < hvt_pkg::VEC_N; k++) begin
            a = longint'($signed(comp_in[k]));
            b = longint'($signed(matrix_elem(k, j)));
            acc = acc + (a * b);
         end
         col_sum[j] = clamp_word(acc >>> hvt_pkg::FRAC_BITS, saturated);
      end
      res.status = hvt_pkg::STATUS_OK;
      if (cmd == hvt_pkg::CMD_POINT) begin
         divisor = col_sum[3];
         if (divisor == 0) begin
            for (int j = 0; j < hvt_pkg::VEC_N; j++) begin
               col_sum[j] = 0;
            end
            res.status = hvt_pkg::STATUS_DIV0;
         end else begin
            for (int j = 0; j < hvt_pkg::VEC_N; j++) begin
               // Signed division truncates toward zero, as the block must.
               quot = (col_sum[j] <<< hvt_pkg::FRAC_BITS) / divisor;
               col_sum[j] = clamp_word(quot, saturated);
            end
         end
      end
      if (res.status != hvt_pkg::STATUS_DIV0 && saturated) begin
         res.status = hvt_pkg::STATUS_SAT;
      end
      for (int j = 0; j < hvt_pkg::VEC_N; j++) begin
         res.comp[j] = col_sum[j][hvt_pkg::DATA_W-1:0];
      end
      return res;
   endfunction

   // Mostly moderate magnitudes so that sums and quotients stay in range, with
   // extremes and full-width words mixed in.
   function automatic logic [hvt_pkg::DATA_W-1:0] pick_word(int max_shift);
      logic signed [hvt_pkg::DATA_W-1:0] v;
      int                                sel;
      sel = $urandom_range(0, 15);
      v = $urandom;
      case (sel)
         0: v = hvt_pkg::WORD_MAX;
         1: v = hvt_pkg::WORD_MIN;
         2: v = '0;
         3: v = hvt_pkg::ONE_FIX;
         4: v = NEG_ONE;
         5, 6: v = $urandom;
         default: v = v >>> (31 - $urandom_range(4, max_shift));
      endcase
      return v;
   endfunction

   // The checker only looks at accepted results; ready is driven here alone.
   initial begin : result_receiver
      int stall_left;
      stall_left = 0;
      rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp.ready <= 1'b0;
         end else if (receiver_idle && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 15) - 1;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : result_checker
      transform_result_type got;
      transform_result_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         got.comp = {rsp.out_w, rsp.out_z, rsp.out_y, rsp.out_x};
         got.status = hvt_pkg::status_type'(rsp.status);
         if (got.status <= hvt_pkg::STATUS_DIV0) begin
            status_seen[got.status]++;
         end
         if (pending_results.size() == 0) begin
            error_count++;
            $display("%0t: result item expected none actual %h status %0d",
                     $time, got.comp, got.status);
         end else begin
            want = pending_results.pop_front();
            for (int j = 0; j < hvt_pkg::VEC_N; j++) begin
               if (got.comp[j] !== want.comp[j]) begin
                  error_count++;
                  $display("%0t: %s expected %h actual %h", $time, comp_name[j],
                           want.comp[j], got.comp[j]);
               end
            end
            if (got.status !== want.status) begin
               error_count++;
               $display("%0t: status expected %0d actual %0d", $time, want.status,
                        got.status);
            end
         end
      end
   end

   task automatic send_vector(logic cmd, logic [hvt_pkg::DATA_W-1:0] x,
                              logic [hvt_pkg::DATA_W-1:0] y,
                              logic [hvt_pkg::DATA_W-1:0] z,
                              logic [hvt_pkg::DATA_W-1:0] w);
      @(negedge clock);
      if (sender_idle && $urandom_range(0, 7) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      req.valid <= 1'b1;
      req.cmd <= cmd;
      req.in_x <= x;
      req.in_y <= y;
      req.in_z <= z;
      req.in_w <= w;
      do @(posedge clock); while (!req.ready);
      pending_results.push_back(transform_vector(cmd, x, y, z, w));
      if (cmd == hvt_pkg::CMD_POINT) begin
         point_items++;
      end else begin
         vector_items++;
      end
   endtask

   task automatic send_random_vector();
      send_vector(($urandom_range(0, 1) == 1) ? hvt_pkg::CMD_POINT : hvt_pkg::CMD_VECTOR,
                  pick_word(22), pick_word(22), pick_word(22), pick_word(22));
   endtask

   // Lowers valid right after the last accepted item, then waits for the block to drain.
   task automatic wait_idle();
      @(negedge clock);
      req.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(matrix_reg_type idx, logic [hvt_pkg::REG_W-1:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= hvt_pkg::CSR_ADDR_W'(int'(idx) << hvt_pkg::ADDR_LSB);
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      matrix_shadow[idx] = value;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic load_matrix(matrix_regs_type regs);
      wait_idle();
      for (int i = 0; i < hvt_pkg::NUM_REGS; i++) begin
         csr_write(matrix_reg_type'(i), regs[i]);
      end
      matrix_loads++;
   endtask

   task automatic test_identity();
      // Reset matrix is the identity: vectors pass through; points keep x, y, z, w = 1.0.
      send_vector(hvt_pkg::CMD_VECTOR, '0, '0, '0, '0);
      send_vector(hvt_pkg::CMD_VECTOR, hvt_pkg::WORD_MAX, hvt_pkg::WORD_MIN,
                  hvt_pkg::WORD_MAX, hvt_pkg::WORD_MIN);
      send_vector(hvt_pkg::CMD_VECTOR, ALL_ONES, 32'h1, NEG_ONE, hvt_pkg::ONE_FIX);
      send_vector(hvt_pkg::CMD_POINT, hvt_pkg::ONE_FIX, NEG_2P5, POS_3P25, hvt_pkg::WORD_MAX);
      send_vector(hvt_pkg::CMD_POINT, hvt_pkg::WORD_MIN, hvt_pkg::WORD_MAX, ALL_ONES, '0);
   endtask

   task automatic test_saturation();
      load_matrix(uniform_regs(hvt_pkg::WORD_MAX));
      send_vector(hvt_pkg::CMD_VECTOR, hvt_pkg::WORD_MAX, hvt_pkg::WORD_MAX,
                  hvt_pkg::WORD_MAX, hvt_pkg::WORD_MAX);
      send_vector(hvt_pkg::CMD_VECTOR, hvt_pkg::WORD_MIN, hvt_pkg::WORD_MIN,
                  hvt_pkg::WORD_MIN, hvt_pkg::WORD_MIN);
      send_vector(hvt_pkg::CMD_VECTOR, 32'h1, '0, '0, '0);
      send_vector(hvt_pkg::CMD_POINT, '0, '0, '0, hvt_pkg::WORD_MIN);
      send_vector(hvt_pkg::CMD_POINT, hvt_pkg::WORD_MAX, hvt_pkg::WORD_MIN,
                  hvt_pkg::WORD_MAX, '0);
   endtask

   task automatic test_divide_cases();
      matrix_regs_type m;
      // No w column at all: every point transform divides by zero.
      m = identity_regs();
      m[ROW3_COLS23] = '0;
      load_matrix(m);
      send_vector(hvt_pkg::CMD_POINT, 32'h0005_0000, 32'h0006_0000, 32'h0007_0000,
                  32'h0008_0000);
      send_vector(hvt_pkg::CMD_POINT, hvt_pkg::WORD_MIN, hvt_pkg::WORD_MAX, '0, '0);
      send_vector(hvt_pkg::CMD_VECTOR, hvt_pkg::WORD_MIN, hvt_pkg::WORD_MAX, '0,
                  hvt_pkg::ONE_FIX);
      // A w sum of one LSB pushes the quotients of the larger components out of range.
      m[ROW3_COLS23] = {32'h1, 32'h0};
      load_matrix(m);
      send_vector(hvt_pkg::CMD_POINT, hvt_pkg::ONE_FIX, NEG_ONE, 32'h2, '0);
      send_vector(hvt_pkg::CMD_POINT, '0, '0, '0, '0);
      // A negative divisor with inexact quotients rounds toward zero.
      m[ROW3_COLS23] = {NEG_THREE, 32'h0};
      load_matrix(m);
      send_vector(hvt_pkg::CMD_POINT, hvt_pkg::ONE_FIX, NEG_ONE, 32'h7, '0);
      // Fractional elements make negative products round toward minus infinity.
      m[ROW0_COLS01] = {32'h0, ONE_HALF};
      m[ROW1_COLS01] = {NEG_HALF, 32'h0};
      m[ROW2_COLS23] = {32'h0, 32'h3};
      m[ROW3_COLS23] = {hvt_pkg::ONE_FIX, 32'h0};
      load_matrix(m);
      send_vector(hvt_pkg::CMD_VECTOR, ALL_ONES, ALL_ONES, ALL_ONES, 32'h5);
      send_vector(hvt_pkg::CMD_VECTOR, 32'h3, 32'h3, 32'h3, 32'hFFFF_FFFB);
   endtask

   task automatic test_random_matrices();
      matrix_regs_type m;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            1: m = uniform_regs(hvt_pkg::WORD_MAX);
            3: m = uniform_regs(hvt_pkg::WORD_MIN);
            5: m = uniform_regs(ALL_ONES);
            7: m = uniform_regs('0);
            default: begin
               for (int i = 0; i < hvt_pkg::NUM_REGS; i++) begin
                  m[i] = {pick_word(19), pick_word(19)};
               end
            end
         endcase
         load_matrix(m);
         sender_idle = ($urandom_range(0, 3) != 0);
         receiver_idle = ($urandom_range(0, 3) != 0);
         repeat (PHASE_ITEMS) send_random_vector();
      end
      sender_idle = 1'b1;
      receiver_idle = 1'b1;
   endtask

   task automatic test_backpressure();
      matrix_regs_type m;
      for (int i = 0; i < hvt_pkg::NUM_REGS; i++) begin
         m[i] = {pick_word(19), pick_word(19)};
      end
      load_matrix(m);
      // The receiver stops for a long stretch while items keep coming, so the
      // pipeline fills and the input side has to stall.
      sender_idle = 1'b0;
      hold_cycles = HOLD_CYCLES;
      repeat (HOLD_ITEMS) send_random_vector();
      sender_idle = 1'b1;
   endtask

   task automatic test_full_rate();
      matrix_regs_type m;
      for (int i = 0; i < hvt_pkg::NUM_REGS; i++) begin
         m[i] = {pick_word(19), pick_word(19)};
      end
      load_matrix(m);
      sender_idle = 1'b0;
      receiver_idle = 1'b0;
      repeat (FULL_RATE_ITEMS) send_random_vector();
   endtask

   initial begin
      reset = 1'b1;
      req.valid = 1'b0;
      req.cmd = hvt_pkg::CMD_VECTOR;
      req.in_x = '0;
      req.in_y = '0;
      req.in_z = '0;
      req.in_w = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      matrix_shadow = identity_regs();
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_identity();
      test_saturation();
      test_divide_cases();
      test_random_matrices();
      test_backpressure();
      test_full_rate();
      wait_idle();

      $display("Ran %0d point and %0d vector items over %0d matrix settings.",
               point_items, vector_items, matrix_loads + 1);
      $display("Results seen: %0d ok, %0d saturated, %0d divide by zero; %0d mismatches.",
               status_seen[hvt_pkg::STATUS_OK], status_seen[hvt_pkg::STATUS_SAT],
               status_seen[hvt_pkg::STATUS_DIV0], error_count);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

`default_nettype wire
